[sv/tspc_pkg.sv]
// Package for the tile and sprite pixel compositor.
// Holds sizes, codes, register indexes and the sequencer state type. No dependencies.
`default_nettype none
package tspc_pkg;
    localparam int unsigned VideoMemBytes    = 8192;
    localparam int unsigned SpriteTableBytes = 160;
    localparam int unsigned ScreenWidth      = 160;
    localparam int unsigned ScreenHeight     = 144;

    localparam logic [1:0] OP_DRAW   = 2'd0;
    localparam logic [1:0] OP_VWRITE = 2'd1;
    localparam logic [1:0] OP_SWRITE = 2'd2;

    localparam logic [2:0] REG_LCDC = 3'd0;
    localparam logic [2:0] REG_SCX  = 3'd1;
    localparam logic [2:0] REG_SCY  = 3'd2;
    localparam logic [2:0] REG_WX   = 3'd3;
    localparam logic [2:0] REG_WY   = 3'd4;
    localparam logic [2:0] REG_BGP  = 3'd5;
    localparam logic [2:0] REG_OBP0 = 3'd6;
    localparam logic [2:0] REG_OBP1 = 3'd7;

    localparam logic [1:0] LAYER_BLANK  = 2'd0;
    localparam logic [1:0] LAYER_BG     = 2'd1;
    localparam logic [1:0] LAYER_WINDOW = 2'd2;
    localparam logic [1:0] LAYER_SPRITE = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MAP_RD, ST_MAP_WT, ST_LO_RD, ST_LO_WT, ST_HI_RD, ST_HI_WT, ST_TILE_DONE,
        ST_SPR_Y, ST_SPR_X, ST_SPR_T, ST_SPR_A, ST_SPR_CHK,
        ST_SLO_RD, ST_SLO_WT, ST_SHI_RD, ST_SHI_WT, ST_SPR_COL,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

[sv/tile_sprite_pixel_compositor.sv]
// Top level of the tile and sprite pixel compositor: APB registers, sequencer, memories.
// Depends on tspc_pkg and tspc_ram.
//
// channel  | direction | signals
// input    | in        | i_valid/o_ready, i_opcode, i_mem_address, i_mem_data, i_line,
//          |           | i_column, i_layer_enables
// result   | out       | o_valid/i_ready, o_shade, o_source_layer
// config   | in        | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// A write transfer completes in its accept cycle. Between accept and output, a pixel reads
// a map byte and two tile bytes per tile layer, the four bytes of each of up to 40 sprite
// entries scanned and two pattern bytes for each sprite that covers it, one read at a
// time through the single sprite table and video memory read ports.
// Reset is synchronous; memories are not cleared. Output is registered; a stalled
// result holds the sequencer and o_ready stays low until it is taken.
`default_nettype none
module tile_sprite_pixel_compositor #(
    parameter int unsigned VIDEO_MEM_BYTES    = tspc_pkg::VideoMemBytes,
    parameter int unsigned SPRITE_TABLE_BYTES = tspc_pkg::SpriteTableBytes,
    parameter int unsigned SCREEN_WIDTH       = tspc_pkg::ScreenWidth,
    parameter int unsigned SCREEN_HEIGHT      = tspc_pkg::ScreenHeight
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_opcode,
    input  wire  [12:0] i_mem_address,
    input  wire  [7:0]  i_mem_data,
    input  wire  [7:0]  i_line,
    input  wire  [7:0]  i_column,
    input  wire  [2:0]  i_layer_enables,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [2:0]  o_shade,
    output logic [1:0]  o_source_layer,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned VAW = $clog2(VIDEO_MEM_BYTES);
    localparam int unsigned SAW = $clog2(SPRITE_TABLE_BYTES);
    localparam int unsigned NSPR = SPRITE_TABLE_BYTES / 4;
    localparam int unsigned IW = (NSPR > 1) ? $clog2(NSPR) : 1;

    tspc_pkg::t_state r_state, n_state;
    logic [7:0] r_regs [8];

    // Latched item
    logic [7:0] r_line, r_col;
    logic [2:0] r_en;
    // Tile fetch working regs
    logic       r_is_win;            // 0 background pass, 1 window pass
    logic [7:0] r_mx, r_my, r_tile, r_lo;
    logic [1:0] r_bgc, r_winc;
    logic [2:0] r_shade;
    logic [1:0] r_layer;
    // Sprite scan
    logic [IW-1:0] r_idx;
    logic [7:0] r_sy, r_sx, r_st, r_sa;
    logic [2:0] r_px, r_py;

    assign pready = 1'b1;
    always_comb begin
        prdata = {24'd0, r_regs[paddr[4:2]]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs[0] <= 8'd145; r_regs[1] <= 8'd0; r_regs[2] <= 8'd0; r_regs[3] <= 8'd0;
            r_regs[4] <= 8'd0;   r_regs[5] <= 8'd252; r_regs[6] <= 8'd255; r_regs[7] <= 8'd255;
        end else if (psel && penable && pwrite) begin
            r_regs[paddr[4:2]] <= pwdata[7:0];
        end
    end

    wire [7:0] lcdc = r_regs[tspc_pkg::REG_LCDC];
    wire accept = i_valid && o_ready;

    // Memories
    logic [VAW-1:0] vr_addr;
    logic [7:0]     vr_data;
    logic [SAW-1:0] sr_addr;
    logic [7:0]     sr_data;
    wire v_we = accept && i_opcode == tspc_pkg::OP_VWRITE;
    wire s_we = accept && i_opcode == tspc_pkg::OP_SWRITE
                && {19'd0, i_mem_address} < SPRITE_TABLE_BYTES;

    tspc_ram #(.WIDTH(8), .DEPTH(VIDEO_MEM_BYTES)) u_vram (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(i_mem_address[VAW-1:0]), .i_wdata(i_mem_data),
        .i_raddr(vr_addr), .o_rdata(vr_data));
    tspc_ram #(.WIDTH(8), .DEPTH(SPRITE_TABLE_BYTES)) u_oam (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(i_mem_address[SAW-1:0]), .i_wdata(i_mem_data),
        .i_raddr(sr_addr), .o_rdata(sr_data));

    // Background / window setup
    wire [7:0] bx = i_column + r_regs[tspc_pkg::REG_SCX];
    wire [7:0] by = i_line + r_regs[tspc_pkg::REG_SCY];
    wire [8:0] wxs = {1'b0, r_regs[tspc_pkg::REG_WX]} - 9'd7;   // may be negative
    wire win_hit = r_en[1] && lcdc[5] && r_line >= r_regs[tspc_pkg::REG_WY]
                   && ($signed({1'b0, r_col}) >= $signed(wxs));
    wire [7:0] win_mx = r_col - wxs[7:0];
    wire [7:0] win_my = r_line - r_regs[tspc_pkg::REG_WY];
    wire bg_on = i_layer_enables[0] && lcdc[0];

    wire map_sel = r_is_win ? lcdc[6] : lcdc[3];
    wire [12:0] map_addr = {2'b11, map_sel, r_my[7:3], r_mx[7:3]};
    wire [8:0]  tnum = (!lcdc[4] && !r_tile[7]) ? {1'b1, r_tile} : {1'b0, r_tile};
    wire [12:0] tl_addr = {tnum, r_my[2:0], 1'b0};
    wire [2:0]  tsh = 3'd7 - r_mx[2:0];
    wire [1:0]  tcol = {vr_data[tsh], r_lo[tsh]};
    wire [1:0]  bg_shade = r_regs[tspc_pkg::REG_BGP][{tcol, 1'b0} +: 2];

    // Sprite check (combinational on latched entry)
    wire [8:0] l9 = {1'b0, r_line}, c9 = {1'b0, r_col};
    wire [8:0] sy9 = {1'b0, r_sy}, sx9 = {1'b0, r_sx};
    wire in_x  = (c9 + 9'd8 >= sx9) && (c9 < sx9);
    wire in_up = (l9 + 9'd16 >= sy9) && (l9 + 9'd8 < sy9);
    wire in_lo = lcdc[2] && (l9 + 9'd8 >= sy9) && (l9 < sy9);
    wire [2:0] spx0 = r_col[2:0] - r_sx[2:0];
    wire [2:0] spy0 = r_line[2:0] - r_sy[2:0];
    wire [7:0] stile = lcdc[2] ? ((in_lo != r_sa[6]) ? (r_st | 8'd1) : (r_st & 8'hFE))
                               : r_st;
    wire [12:0] sl_addr = {1'b0, stile, r_py, 1'b0};
    wire [2:0]  ssh = 3'd7 - r_px;
    wire [1:0]  scol = {vr_data[ssh], r_lo[ssh]};
    wire [7:0]  opal = r_sa[4] ? r_regs[tspc_pkg::REG_OBP1] : r_regs[tspc_pkg::REG_OBP0];
    wire last_spr = ({{(32-IW){1'b0}}, r_idx} == NSPR - 1);
    wire [SAW-1:0] sbase = SAW'({r_idx, 2'b00});

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tspc_pkg::ST_IDLE: begin
                if (accept && i_opcode == tspc_pkg::OP_DRAW
                    && {24'd0, i_line} < SCREEN_HEIGHT && {24'd0, i_column} < SCREEN_WIDTH) begin
                    n_state = bg_on ? tspc_pkg::ST_MAP_RD : tspc_pkg::ST_TILE_DONE;
                end
            end
            tspc_pkg::ST_MAP_RD:  n_state = tspc_pkg::ST_MAP_WT;
            tspc_pkg::ST_MAP_WT:  n_state = tspc_pkg::ST_LO_RD;
            tspc_pkg::ST_LO_RD:   n_state = tspc_pkg::ST_LO_WT;
            tspc_pkg::ST_LO_WT:   n_state = tspc_pkg::ST_HI_RD;
            tspc_pkg::ST_HI_RD:   n_state = tspc_pkg::ST_HI_WT;
            tspc_pkg::ST_HI_WT:   n_state = tspc_pkg::ST_TILE_DONE;
            tspc_pkg::ST_TILE_DONE: begin
                if (!r_is_win && win_hit) n_state = tspc_pkg::ST_MAP_RD;
                else if (r_en[2])         n_state = tspc_pkg::ST_SPR_Y;
                else                      n_state = tspc_pkg::ST_OUT;
            end
            tspc_pkg::ST_SPR_Y:   n_state = tspc_pkg::ST_SPR_X;
            tspc_pkg::ST_SPR_X:   n_state = tspc_pkg::ST_SPR_T;
            tspc_pkg::ST_SPR_T:   n_state = tspc_pkg::ST_SPR_A;
            tspc_pkg::ST_SPR_A:   n_state = tspc_pkg::ST_SPR_CHK;
            tspc_pkg::ST_SPR_CHK: begin
                if (in_x && (in_up || in_lo)) n_state = tspc_pkg::ST_SLO_RD;
                else if (last_spr)            n_state = tspc_pkg::ST_OUT;
                else                          n_state = tspc_pkg::ST_SPR_Y;
            end
            tspc_pkg::ST_SLO_RD:  n_state = tspc_pkg::ST_SLO_WT;
            tspc_pkg::ST_SLO_WT:  n_state = tspc_pkg::ST_SHI_RD;
            tspc_pkg::ST_SHI_RD:  n_state = tspc_pkg::ST_SHI_WT;
            tspc_pkg::ST_SHI_WT:  n_state = tspc_pkg::ST_SPR_COL;
            tspc_pkg::ST_SPR_COL: begin
                if (scol != 2'd0 || last_spr) n_state = tspc_pkg::ST_OUT;
                else                          n_state = tspc_pkg::ST_SPR_Y;
            end
            tspc_pkg::ST_OUT:     if (i_ready) n_state = tspc_pkg::ST_IDLE;
            default:              n_state = tspc_pkg::ST_IDLE;
        endcase
    end

    // Outputs / memory addresses
    always_comb begin
        o_ready = 1'b0;
        o_valid = 1'b0;
        vr_addr = map_addr[VAW-1:0];
        sr_addr = sbase;
        unique case (r_state)
            tspc_pkg::ST_IDLE:   o_ready = 1'b1;
            tspc_pkg::ST_LO_RD:  vr_addr = tl_addr[VAW-1:0];
            tspc_pkg::ST_HI_RD:  vr_addr = tl_addr[VAW-1:0] | VAW'(1);
            tspc_pkg::ST_SLO_RD: vr_addr = sl_addr[VAW-1:0];
            tspc_pkg::ST_SHI_RD,
            tspc_pkg::ST_SHI_WT: vr_addr = sl_addr[VAW-1:0] | VAW'(1);
            tspc_pkg::ST_SPR_Y:  sr_addr = sbase;
            tspc_pkg::ST_SPR_X:  sr_addr = sbase | SAW'(1);
            tspc_pkg::ST_SPR_T:  sr_addr = sbase | SAW'(2);
            tspc_pkg::ST_SPR_A:  sr_addr = sbase | SAW'(3);
            tspc_pkg::ST_OUT:    o_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tspc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            tspc_pkg::ST_IDLE: begin
                r_line <= i_line; r_col <= i_column; r_en <= i_layer_enables;
                r_mx <= bx; r_my <= by; r_is_win <= 1'b0;
                r_bgc <= 2'd0; r_winc <= 2'd0;
                r_shade <= 3'd4; r_layer <= tspc_pkg::LAYER_BLANK;
                r_idx <= '0;
            end
            tspc_pkg::ST_MAP_WT: r_tile <= vr_data;
            tspc_pkg::ST_LO_WT,
            tspc_pkg::ST_SLO_WT: r_lo <= vr_data;
            tspc_pkg::ST_HI_WT: begin
                r_shade <= {1'b0, bg_shade};
                if (r_is_win) begin
                    r_winc <= tcol; r_layer <= tspc_pkg::LAYER_WINDOW;
                end else begin
                    r_bgc <= tcol; r_layer <= tspc_pkg::LAYER_BG;
                end
            end
            tspc_pkg::ST_TILE_DONE: begin
                r_is_win <= 1'b1; r_mx <= win_mx; r_my <= win_my;
            end
            tspc_pkg::ST_SPR_X: r_sy <= sr_data;
            tspc_pkg::ST_SPR_T: r_sx <= sr_data;
            tspc_pkg::ST_SPR_A: r_st <= sr_data;
            tspc_pkg::ST_SPR_CHK: begin
                r_sa <= sr_data;
                r_px <= sr_data[5] ? ~spx0 : spx0;
                r_py <= sr_data[6] ? ~spy0 : spy0;
                if (!(in_x && (in_up || in_lo))) r_idx <= r_idx + IW'(1);
            end
            tspc_pkg::ST_SPR_COL: begin
                if (scol != 2'd0) begin
                    if (!r_sa[7] || (r_bgc == 2'd0 && r_winc == 2'd0)) begin
                        r_shade <= {1'b0, opal[{scol, 1'b0} +: 2]};
                        r_layer <= tspc_pkg::LAYER_SPRITE;
                    end
                end else begin
                    r_idx <= r_idx + IW'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_shade = r_shade;
    assign o_source_layer = r_layer;
endmodule
`default_nettype wire

[sv/tspc_ram.sv]
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module tspc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
